// ===== rtl/core/sorted_priority_job_queue_top_assert.svh =====
// Assertion macros for the sorted priority job queue.
`ifndef SORTED_PRIORITY_JOB_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_JOB_QUEUE_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SPJQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SPJQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/spjq_pkg.sv =====
// Shared types and constants for the sorted priority job queue.
`default_nettype none
package spjq_pkg;
    localparam int DEPTH = 16;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_REMOVED = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic [7:0] prio;
        logic [15:0] client;
        logic [15:0] delay;
        logic [31:0] path;
    } job_t;

    typedef struct packed {
        logic do_add;
        logic do_remove;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/sorted_priority_job_queue_top.sv =====
// The result is registered and valid in the cycle after the request item is accepted.
// Throughput: one item per cycle unless in_stall (single-stage compare and shift array);
// the output register takes a new result while the previous one is taken in the same cycle.
// Reset: rst_n asynchronous active low empties the queue and clears the result valid.
// Entry storage holds no reset value; only occupied slots ever reach the output.
`default_nettype none
module sorted_priority_job_queue_top (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire logic mode,
    input wire logic [7:0] job_priority,
    input wire logic [15:0] client_handle,
    input wire logic [15:0] delay_secs,
    input wire logic [31:0] path_handle,
    output logic out_valid,
    input wire logic out_stall,
    output logic [1:0] status,
    output logic [7:0] out_priority,
    output logic [15:0] out_client,
    output logic [15:0] out_delay,
    output logic [31:0] out_path,
    output logic [spjq_pkg::OCC_W-1:0] occupancy
);
    import spjq_pkg::*;

    dp_cmd_t cmd;
    dp_stat_t stat;
    job_t new_job, front_job, out_job;
    logic [CW-1:0] count_next;

    assign new_job.prio = job_priority;
    assign new_job.client = client_handle;
    assign new_job.delay = delay_secs;
    assign new_job.path = path_handle;

    spjq_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .new_job(new_job),
        .stat(stat), .front_job(front_job), .count_next(count_next)
    );

    spjq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .out_valid(out_valid), .out_stall(out_stall),
        .stat(stat), .front_job(front_job), .count_next(count_next),
        .cmd(cmd), .status(status), .out_job(out_job), .occupancy(occupancy)
    );

    assign out_priority = out_job.prio;
    assign out_client = out_job.client;
    assign out_delay = out_job.delay;
    assign out_path = out_job.path;
endmodule
`default_nettype wire

// ===== rtl/core/spjq_datapath.sv =====
// Register array with parallel compare, insert shift and remove shift.
`default_nettype none
module spjq_datapath (
    input wire logic clk,
    input wire logic rst_n,
    input wire spjq_pkg::dp_cmd_t cmd,
    input wire spjq_pkg::job_t new_job,
    output spjq_pkg::dp_stat_t stat,
    output spjq_pkg::job_t front_job,
    output logic [spjq_pkg::CW-1:0] count_next
);
    import spjq_pkg::*;

    job_t entry_reg [DEPTH];
    logic [CW-1:0] count_reg;
    logic [DEPTH-1:0] behind;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            behind[i] = (CW'(i) < count_reg) && (new_job.prio <= entry_reg[i].prio);
        end
    end

    assign stat.full = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign front_job = entry_reg[0];

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_add)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.do_remove)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cmd.do_add && !behind[i])
            begin
                if (i == 0 || behind[(i == 0) ? 0 : i - 1])
                begin
                    entry_reg[i] <= new_job;
                end
                else
                begin
                    entry_reg[i] <= entry_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (cmd.do_remove && i < DEPTH - 1)
            begin
                entry_reg[i] <= entry_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `include "sorted_priority_job_queue_top_assert.svh"
    `SPJQ_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `SPJQ_ASSERT_IMP(a_no_add_full, clk, rst_n, cmd.do_add, !stat.full)
    `SPJQ_ASSERT_IMP(a_no_rm_empty, clk, rst_n, cmd.do_remove, !stat.empty)
    `SPJQ_ASSERT_NEXT(a_add_cnt, clk, rst_n, cmd.do_add, count_reg == $past(count_reg) + CW'(1))
endmodule
`default_nettype wire

// ===== rtl/core/spjq_ctrl.sv =====
// Request controller: decodes the item, drives the datapath, holds the result.
`default_nettype none
module spjq_ctrl (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire logic mode,
    output logic out_valid,
    input wire logic out_stall,
    input wire spjq_pkg::dp_stat_t stat,
    input wire spjq_pkg::job_t front_job,
    input wire logic [spjq_pkg::CW-1:0] count_next,
    output spjq_pkg::dp_cmd_t cmd,
    output logic [1:0] status,
    output spjq_pkg::job_t out_job,
    output logic [spjq_pkg::OCC_W-1:0] occupancy
);
    import spjq_pkg::*;

    typedef enum logic [1:0] {
        S_EMPTY = 2'b01,
        S_FULL = 2'b10
    } ostate_t;

    ostate_t ostate_reg, ostate_next;
    logic take;
    logic [1:0] status_reg;
    job_t job_reg;
    logic [OCC_W-1:0] occ_reg;

    assign in_stall = (ostate_reg == S_FULL) && out_stall;
    assign take = in_valid && !in_stall;
    assign cmd.do_add = take && (mode == MODE_ADD) && !stat.full;
    assign cmd.do_remove = take && (mode != MODE_ADD) && !stat.empty;

    always_comb
    begin
        case (ostate_reg)
            S_EMPTY: ostate_next = take ? S_FULL : S_EMPTY;
            S_FULL: ostate_next = (take || out_stall) ? S_FULL : S_EMPTY;
            default: ostate_next = S_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ostate_reg <= S_EMPTY;
        end
        else
        begin
            ostate_reg <= ostate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            occ_reg <= OCC_W'(count_next);
            job_reg <= cmd.do_remove ? front_job : '0;
            if (mode == MODE_ADD)
            begin
                status_reg <= stat.full ? ST_FULL : ST_ADDED;
            end
            else
            begin
                status_reg <= stat.empty ? ST_EMPTY : ST_REMOVED;
            end
        end
    end

    assign out_valid = (ostate_reg == S_FULL);
    assign status = status_reg;
    assign out_job = job_reg;
    assign occupancy = occ_reg;

    `include "sorted_priority_job_queue_top_assert.svh"
    `SPJQ_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, !(cmd.do_add && cmd.do_remove))
    `SPJQ_ASSERT_NEXT(a_take_valid, clk, rst_n, take, out_valid)
    `SPJQ_ASSERT_IMP(a_cmd_take, clk, rst_n, cmd.do_add || cmd.do_remove, take)
endmodule
`default_nettype wire

// ===== verif/tb_sorted_priority_job_queue_top.sv =====
// Self-checking testbench for the sorted priority job queue with a queue model.
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_priority_job_queue_top;
    import spjq_pkg::*;

    class job_queue_scoreboard;
        job_t jobs[$];
        logic [1:0] exp_status[$];
        job_t exp_job[$];
        logic [OCC_W-1:0] exp_occ[$];
        int errors;
        int removed_cnt;
        int full_cnt;
        int empty_cnt;

        function void note_request(logic m, job_t j);
            job_t r;
            int slot;
            logic [1:0] st;
            r = '0;
            if (m == MODE_ADD)
            begin
                if (jobs.size() >= DEPTH)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    slot = 0;
                    while (slot < jobs.size() && j.prio <= jobs[slot].prio)
                        slot++;
                    jobs.insert(slot, j);
                    st = ST_ADDED;
                end
            end
            else
            begin
                if (jobs.size() == 0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    r = jobs.pop_front();
                    st = ST_REMOVED;
                end
            end
            exp_status.push_back(st);
            exp_job.push_back(r);
            exp_occ.push_back(OCC_W'(jobs.size()));
        endfunction

        function void check_result(logic [1:0] st, job_t j, logic [OCC_W-1:0] occ);
            logic [1:0] es;
            job_t ej;
            logic [OCC_W-1:0] eo;
            if (exp_status.size() == 0)
            begin
                $error("unexpected result status=%0d", st);
                errors++;
                return;
            end
            es = exp_status.pop_front();
            ej = exp_job.pop_front();
            eo = exp_occ.pop_front();
            if (es == ST_REMOVED) removed_cnt++;
            if (es == ST_FULL) full_cnt++;
            if (es == ST_EMPTY) empty_cnt++;
            if (st !== es)
            begin
                $error("status expected %0d actual %0d", es, st); errors++;
            end
            if (j.prio !== ej.prio)
            begin
                $error("out_priority expected %0d actual %0d", ej.prio, j.prio); errors++;
            end
            if (j.client !== ej.client)
            begin
                $error("out_client expected %0h actual %0h", ej.client, j.client); errors++;
            end
            if (j.delay !== ej.delay)
            begin
                $error("out_delay expected %0h actual %0h", ej.delay, j.delay); errors++;
            end
            if (j.path !== ej.path)
            begin
                $error("out_path expected %0h actual %0h", ej.path, j.path); errors++;
            end
            if (occ !== eo)
            begin
                $error("occupancy expected %0d actual %0d", eo, occ); errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic [7:0] job_priority = '0;
    logic [15:0] client_handle = '0;
    logic [15:0] delay_secs = '0;
    logic [31:0] path_handle = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [1:0] status;
    logic [7:0] out_priority;
    logic [15:0] out_client;
    logic [15:0] out_delay;
    logic [31:0] out_path;
    logic [OCC_W-1:0] occupancy;

    job_queue_scoreboard sb = new();
    int cycle_cnt = 0;
    int sent_cnt = 0;
    bit quiet_phase = 1'b0;
    bit hold_off = 1'b0;
    bit driving_done = 1'b0;

    sorted_priority_job_queue_top uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .job_priority(job_priority), .client_handle(client_handle),
        .delay_secs(delay_secs), .path_handle(path_handle), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .out_priority(out_priority),
        .out_client(out_client), .out_delay(out_delay), .out_path(out_path),
        .occupancy(occupancy)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        job_t j;
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && in_valid && !in_stall)
        begin
            j.prio = job_priority;
            j.client = client_handle;
            j.delay = delay_secs;
            j.path = path_handle;
            sb.note_request(mode, j);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            j.prio = out_priority;
            j.client = out_client;
            j.delay = out_delay;
            j.path = out_path;
            sb.check_result(status, j, occupancy);
        end
        if (cycle_cnt > 200000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall, long hold-off when asked, no stall in the quiet phase
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (quiet_phase)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 35);
    end

    task automatic send_item(logic m, logic [7:0] p, logic [15:0] c, logic [15:0] d,
                             logic [31:0] ph);
        if (!quiet_phase)
        begin
            while ($urandom_range(99) < 35)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        mode <= m;
        job_priority <= p;
        client_handle <= c;
        delay_secs <= d;
        path_handle <= ph;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        sent_cnt++;
    endtask

    task automatic send_random(int add_pct, int prio_span);
        send_item(($urandom_range(99) < add_pct) ? MODE_ADD : MODE_REMOVE,
                  8'(255 - $urandom_range(prio_span)), 16'($urandom),
                  16'($urandom), $urandom);
    endtask

    initial
    begin
        int k;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: empty remove, extremes, equal priorities, fill past full, partial drain
        send_item(MODE_REMOVE, 8'hff, 16'hffff, 16'hffff, 32'hffffffff);
        send_item(MODE_ADD, 8'h00, 16'h0000, 16'h0000, 32'h00000000);
        send_item(MODE_ADD, 8'hff, 16'hffff, 16'hffff, 32'hffffffff);
        send_item(MODE_ADD, 8'h80, 16'h1111, 16'h2222, 32'h33333333);
        send_item(MODE_ADD, 8'h80, 16'h4444, 16'h5555, 32'h66666666);
        for (k = 0; k < 14; k++)
            send_item(MODE_ADD, 8'(k * 19), 16'(k), 16'(k + 100), 32'(k * 7));
        for (k = 0; k < 6; k++)
            send_item(MODE_REMOVE, 8'h00, 16'h0000, 16'h0000, 32'h00000000);

        for (k = 0; k < 400; k++)
            send_random(50, 255);
        // mostly adds, with the receiver held off at the start
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            for (k = 0; k < 60; k++)
                send_random(80, 255);
        join
        quiet_phase = 1'b1;
        for (k = 0; k < 300; k++)
            send_random(55, 7);
        quiet_phase = 1'b0;
        for (k = 0; k < 400; k++)
            send_random(70, 15);
        for (k = 0; k < 400; k++)
            send_random(30, 255);
        for (k = 0; k < 360; k++)
            send_random(50, 3);
        in_valid <= 1'b0;
        driving_done = 1'b1;
    end

    initial
    begin
        wait (driving_done);
        while (sb.exp_status.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("%0d items sent: %0d removed, %0d rejected full, %0d empty removes",
                 sent_cnt, sb.removed_cnt, sb.full_cnt, sb.empty_cnt);
        if (sb.errors == 0 && sb.exp_status.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
